>>> design/tbcc_pkg.sv
package tbcc_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned CODE_W  = 6;
   localparam int unsigned CLASS_W = 3;

   // click classes before the long bit is added
   localparam logic [CLASS_W-1:0] CLS_LEFT  = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_RIGHT = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_BOTH  = 3'd4;

   localparam logic [CODE_W-1:0] CODE_RADIX = 6'd6;

   // configuration register indexes
   localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [1:0] REG_LONG_THR  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT   = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [CFG_W-1:0] LONG_THR_RESET = 16'd165;
   localparam logic [CFG_W-1:0] TIMEOUT_RESET  = 16'd500;

   // input kind
   localparam logic MODE_EDGE  = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct packed {
      logic              reset_notice;
      logic              press_notice;
      logic              key_valid;
      logic [CODE_W-1:0] key_code;
   } result_type;

endpackage

>>> design/two_button_chord_click_decoder_top.sv
// Two-button chord click decoder. Each request is a button edge (tuser mode 0,
// with the button number) or a timeout check (mode 1), stamped with a wrapping
// millisecond time; every request gives exactly one response. Edges within the
// debounce time of that button's last accepted edge are dropped. A press sets
// press_notice; a release that ends a click classifies it (short/long x
// left/right/both) and the second click of a pair yields key_valid with a
// code 0..35. A check past the timeout with one click pending clears the
// decoder and sets reset_notice. Throughput is one request per cycle while
// responses are taken; a request passes the request register, then the
// response register, and the decoder state is updated in the single pass
// between them. All time differences are 32-bit wrapping values compared
// as signed numbers. Configuration writes take effect on the next cycle and
// should be made while no request is in flight.
module two_button_chord_click_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   input  logic [1:0]  req_tuser,   // [0] mode, [1] button
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] key_code, [7:6] zero
   output logic [2:0]  rsp_tuser,   // [0] key_valid, [1] press_notice, [2] reset_notice
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned TW = tbcc_pkg::TIME_W;
   localparam int unsigned CW = tbcc_pkg::CODE_W;

   // configuration
   logic [tbcc_pkg::CFG_W-1:0] debounce_ff, long_thr_ff, timeout_ff;

   // request register
   logic          in_valid_ff;
   logic          in_mode_ff;
   logic          in_button_ff;
   logic [TW-1:0] in_now_ff;

   // decoder state
   logic [1:0]          level_ff, level_in;
   logic [1:0]          in_click_ff, in_click_in;
   logic [1:0][TW-1:0]  last_edge_ff, last_edge_in;
   logic [CW-1:0]       code_acc_ff, code_acc_in;
   logic                pending_ff, pending_in;

   // response register
   logic                   rsp_valid_ff;
   tbcc_pkg::result_type   rsp_ff, result;

   logic out_free, fire;

   // handshake: the response register frees up when it is empty or its response is taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= tbcc_pkg::DEBOUNCE_RESET;
         long_thr_ff <= tbcc_pkg::LONG_THR_RESET;
         timeout_ff  <= tbcc_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tbcc_pkg::REG_DEBOUNCE: debounce_ff <= csr_wdata;
            tbcc_pkg::REG_LONG_THR: long_thr_ff <= csr_wdata;
            tbcc_pkg::REG_TIMEOUT:  timeout_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff   <= req_tuser[0];
         in_button_ff <= req_tuser[1];
         in_now_ff    <= req_tdata;
      end
   end

   // single decode pass: edge handling, click classification, timeout check
   always_comb begin
      logic [TW-1:0]      age, d0, d1, dmin, newest, idle;
      logic               age_ok, is_short, timed_out, new_level;
      logic [tbcc_pkg::CLASS_W-1:0] cls;

      level_in     = level_ff;
      in_click_in  = in_click_ff;
      last_edge_in = last_edge_ff;
      code_acc_in  = code_acc_ff;
      pending_in   = pending_ff;
      result       = '0;

      age    = in_now_ff - last_edge_ff[in_button_ff];
      age_ok = $signed(age) > $signed({16'd0, debounce_ff});
      new_level = ~level_ff[in_button_ff];

      // hold time: youngest of the two stamps
      d0   = in_now_ff - last_edge_ff[0];
      d1   = in_now_ff - last_edge_ff[1];
      dmin = ($signed(d0) < $signed(d1)) ? d0 : d1;
      is_short = $signed(dmin) < $signed({16'd0, long_thr_ff});

      if (in_click_ff[0] && in_click_ff[1]) begin
         cls = tbcc_pkg::CLS_BOTH;
      end else if (in_click_ff[1]) begin
         cls = tbcc_pkg::CLS_RIGHT;
      end else begin
         cls = tbcc_pkg::CLS_LEFT;
      end
      if (!is_short) begin
         cls = cls + 3'd1;
      end

      newest = ($signed(last_edge_ff[0]) < $signed(last_edge_ff[1])) ?
               last_edge_ff[1] : last_edge_ff[0];
      idle      = in_now_ff - newest;
      timed_out = !($signed(idle) < $signed({16'd0, timeout_ff}));

      if (fire) begin
         if (in_mode_ff == tbcc_pkg::MODE_EDGE) begin
            if (age_ok) begin
               level_in[in_button_ff]     = new_level;
               last_edge_in[in_button_ff] = in_now_ff;
               if (new_level) begin
                  in_click_in[in_button_ff] = 1'b1;
                  result.press_notice       = 1'b1;
               end else if (in_click_ff != 2'b00) begin
                  in_click_in = 2'b00;
                  if (pending_ff) begin
                     result.key_valid = 1'b1;
                     result.key_code  = code_acc_ff + CW'(cls);
                     code_acc_in      = '0;
                     pending_in       = 1'b0;
                  end else begin
                     code_acc_in = CW'(cls) * tbcc_pkg::CODE_RADIX;
                     pending_in  = 1'b1;
                  end
               end
            end
         end else if (timed_out && pending_ff) begin
            // discard the half-entered code, clear levels and clicks, keep the stamps
            result.reset_notice = 1'b1;
            level_in    = 2'b00;
            in_click_in = 2'b00;
            code_acc_in = '0;
            pending_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= 2'b00;
         in_click_ff  <= 2'b00;
         last_edge_ff <= '0;
         code_acc_ff  <= '0;
         pending_ff   <= 1'b0;
      end else begin
         level_ff     <= level_in;
         in_click_ff  <= in_click_in;
         last_edge_ff <= last_edge_in;
         code_acc_ff  <= code_acc_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.key_code};
   assign rsp_tuser  = {rsp_ff.reset_notice, rsp_ff.press_notice, rsp_ff.key_valid};

`ifndef ASSERT_OFF
   // at most one kind of notice per response
   a_one_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.reset_notice, rsp_ff.press_notice, rsp_ff.key_valid}))
      else $error("more than one notice in a response");

   // the code field is only nonzero with a completed key
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.key_valid) |-> (rsp_ff.key_code == '0))
      else $error("key_code set without key_valid");

   // with no click pending the accumulator must be clear
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      !pending_ff |-> (code_acc_ff == '0))
      else $error("code accumulator dirty with no pending click");

   // a timeout discard leaves the decoder fully cleared
   a_discard: assert property (@(posedge clock) disable iff (reset)
      (fire && result.reset_notice) |=>
         (!pending_ff && in_click_ff == 2'b00 && level_ff == 2'b00))
      else $error("timeout discard did not clear state");

   // a completed key consumes the pending click
   a_key_done: assert property (@(posedge clock) disable iff (reset)
      (fire && result.key_valid) |-> pending_ff ##1 !pending_ff)
      else $error("key completed without a pending click");
`endif

endmodule
